[sv/range_search_stream_filter_defines.svh]
// Assertion macros for the checker file of the range search filter.
// Depends on nothing; the including scope provides clk and rst_n.
`ifndef RANGE_SEARCH_STREAM_FILTER_DEFINES_SVH
`define RANGE_SEARCH_STREAM_FILTER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define RSF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsf assertion failed");

// Next-cycle implication, checked while out of reset.
`define RSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsf assertion failed");

`endif

[sv/rsf_pkg.sv]
// Shared types, constants and compare helper for the range search filter.
// Used by rsf_heap and range_search_stream_filter; no dependencies.
`timescale 1ns / 1ps

package rsf_pkg;

  localparam int MAX_K   = 256;
  localparam int HEAP_AW = $clog2(MAX_K);
  localparam int CNT_W   = HEAP_AW + 1;

  // register indexes of the configuration port
  localparam logic [2:0] REG_ORDERED   = 3'd0;
  localparam logic [2:0] REG_LARGER    = 3'd1;
  localparam logic [2:0] REG_NEAR_EN   = 3'd2;
  localparam logic [2:0] REG_NEAR      = 3'd3;
  localparam logic [2:0] REG_FAR       = 3'd4;
  localparam logic [2:0] REG_LIMIT     = 3'd5;
  localparam logic [2:0] REG_TOLERANCE = 3'd6;

  typedef enum logic [1:0] {
    T_IDLE,
    T_MUL,
    T_EVAL,
    T_HEAP
  } top_state_t;

  typedef enum logic [1:0] {
    H_IDLE,
    H_SCAN1,
    H_WRITE,
    H_SCAN2
  } heap_state_t;

  typedef enum logic {
    HOP_INSERT,
    HOP_REPLACE
  } heap_op_t;

  typedef struct packed {
    logic               start;
    heap_op_t           op;
    logic [CNT_W-1:0]   count;
    logic signed [31:0] dval;
  } heap_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] worst;
  } heap_rsp_t;

  // a strictly closer than b under the selected metric
  function automatic logic closer(input logic signed [31:0] a,
                                  input logic signed [31:0] b,
                                  input logic lic);
    closer = lic ? (a > b) : (a < b);
  endfunction

endpackage

[sv/rsf_heap.sv]
// Best-distance store with a shared compare unit that scans for the worst entry.
// Depends on rsf_pkg.
`timescale 1ns / 1ps

module rsf_heap (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  prefer_larger,
  input  rsf_pkg::heap_req_t    req,
  output rsf_pkg::heap_rsp_t    rsp
);

  logic signed [31:0] mem [rsf_pkg::MAX_K];

  rsf_pkg::heap_state_t       state_r, state_nxt;
  logic [rsf_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rsf_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic [rsf_pkg::HEAP_AW-1:0] pidx_r, pidx_nxt;
  logic                        pvld_r, pvld_nxt;
  logic [rsf_pkg::HEAP_AW-1:0] widx_r, widx_nxt;
  logic signed [31:0]          wval_r, wval_nxt;
  logic signed [31:0]          dist_r, dist_nxt;
  logic                        done_r, done_nxt;
  logic signed [31:0]          rd_data_r;

  logic                        we;
  logic [rsf_pkg::HEAP_AW-1:0] waddr;
  logic signed [31:0]          wdata;
  logic [rsf_pkg::HEAP_AW-1:0] raddr;
  logic                        issue, scan_end;

  assign issue    = (idx_r < cnt_r);
  assign scan_end = !issue && !pvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_r <= mem[raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsf_pkg::H_IDLE: begin
        if (req.start && req.op == rsf_pkg::HOP_REPLACE) state_nxt = rsf_pkg::H_SCAN1;
      end
      rsf_pkg::H_SCAN1: if (scan_end) state_nxt = rsf_pkg::H_WRITE;
      rsf_pkg::H_WRITE: state_nxt = rsf_pkg::H_SCAN2;
      rsf_pkg::H_SCAN2: if (scan_end) state_nxt = rsf_pkg::H_IDLE;
      default: state_nxt = rsf_pkg::H_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    pidx_nxt = pidx_r;
    pvld_nxt = 1'b0;
    widx_nxt = widx_r;
    wval_nxt = wval_r;
    dist_nxt = dist_r;
    done_nxt = 1'b0;
    we       = 1'b0;
    waddr    = widx_r;
    wdata    = dist_r;
    raddr    = idx_r[rsf_pkg::HEAP_AW-1:0];
    case (state_r)
      rsf_pkg::H_IDLE: begin
        if (req.start) begin
          cnt_nxt  = req.count;
          dist_nxt = req.dval;
          idx_nxt  = '0;
          if (req.op == rsf_pkg::HOP_INSERT) begin
            we       = 1'b1;
            waddr    = req.count[rsf_pkg::HEAP_AW-1:0];
            wdata    = req.dval;
            done_nxt = 1'b1;
          end
        end
      end
      rsf_pkg::H_SCAN1, rsf_pkg::H_SCAN2: begin
        if (issue) begin
          pvld_nxt = 1'b1;
          pidx_nxt = idx_r[rsf_pkg::HEAP_AW-1:0];
          idx_nxt  = idx_r + 1'b1;
        end
        if (pvld_r && (pidx_r == '0 || rsf_pkg::closer(wval_r, rd_data_r, prefer_larger)))
        begin
          wval_nxt = rd_data_r;
          widx_nxt = pidx_r;
        end
        if (state_r == rsf_pkg::H_SCAN2 && scan_end) begin
          done_nxt = 1'b1;
        end
      end
      rsf_pkg::H_WRITE: begin
        we      = 1'b1;
        idx_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsf_pkg::H_IDLE;
      pvld_r  <= 1'b0;
      done_r  <= 1'b0;
      idx_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pvld_r  <= pvld_nxt;
      done_r  <= done_nxt;
      idx_r   <= idx_nxt;
      cnt_r   <= cnt_nxt;
    end
    pidx_r <= pidx_nxt;
    widx_r <= widx_nxt;
    wval_r <= wval_nxt;
    dist_r <= dist_nxt;
  end

  assign rsp.done  = done_r;
  assign rsp.worst = wval_r;

endmodule

[sv/range_search_stream_filter.sv]
// Top level of the range search stream filter: config, per-query state, sequencer.
// Depends on rsf_pkg and rsf_heap.
`timescale 1ns / 1ps
//
//  channel | ports                                      | direction
//  --------+--------------------------------------------+----------
//  in      | in_valid, in_stall, in_first_of_query,     | input
//          | in_cand_id, in_cand_dist                   |
//  out     | out_valid, out_stall, out_keep, out_id,    | output
//          | out_dist, out_stop                         |
//  cfg     | cfg_we, cfg_index, cfg_wdata               | input
//
//  Steps: accept, multiply and decide for each candidate, plus an insert
//  into the best set, or, when the set is full and the worst entry is
//  replaced, a scan, a write and a second scan: the single compare unit in
//  rsf_heap reads one entry per cycle from its memory port in each scan.
//  Reset: synchronous, active low; clears config and per-query state. The
//  best-distance memory is not cleared; only entries below heap_count are read.
//  A finished result waits in the output register; the decide step holds off
//  while an earlier result is still stalled there. in_stall stays high while
//  a candidate is in work, and the block returns to accept once its result
//  has been loaded into the output register.

module range_search_stream_filter (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_first_of_query,
  input  logic [62:0]        in_cand_id,
  input  logic signed [31:0] in_cand_dist,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_keep,
  output logic [62:0]        out_id,
  output logic signed [31:0] out_dist,
  output logic               out_stop,
  // configuration
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata
);

  localparam int CW = rsf_pkg::CNT_W;

  // configuration registers
  logic               ordered_r, larger_r, near_en_r;
  logic signed [31:0] near_r, far_r;
  logic signed [9:0]  limit_r;
  logic [7:0]         tol_r;

  // per-query state
  logic [CW-1:0]      heap_cnt_r, heap_cnt_nxt;
  logic signed [31:0] tight_r, tight_nxt;
  logic [31:0]        seen_r, seen_nxt;
  logic [31:0]        over_r, over_nxt;
  logic [CW-1:0]      kept_r, kept_nxt;
  logic               stopped_r, stopped_nxt;

  // candidate in work
  rsf_pkg::top_state_t state_r, state_nxt;
  logic [62:0]        id_r;
  logic signed [31:0] dist_r;
  logic [39:0]        prod_r, prod_nxt;
  logic               keep_r, keep_nxt;
  logic               stop_r, stop_nxt;
  rsf_pkg::heap_op_t  op_r, op_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               out_keep_r, out_stop_r;
  logic [62:0]        out_id_r;
  logic signed [31:0] out_dist_r;
  logic               out_load;

  rsf_pkg::heap_req_t heap_req;
  rsf_pkg::heap_rsp_t heap_rsp;

  logic               has_lim, lim_zero;
  logic [31:0]        lim_big;
  logic [CW-1:0]      lim_eff;
  logic [31:0]        seen_inc, over_inc;
  logic [CW-1:0]      kept_inc;
  logic [40:0]        thr_sum;
  logic               accept, done_eval, res_ready;

  assign accept    = in_valid && (state_r == rsf_pkg::T_IDLE);
  assign in_stall  = (state_r != rsf_pkg::T_IDLE);
  assign res_ready = !out_valid_r || !out_stall;

  assign has_lim  = !limit_r[9];
  assign lim_big  = 32'(limit_r[8:0]);
  assign lim_eff  = (lim_big > 32'(rsf_pkg::MAX_K)) ? CW'(rsf_pkg::MAX_K) : CW'(lim_big);
  assign lim_zero = has_lim && (lim_eff == '0);

  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + 32'd1;
  assign over_inc = (over_r == '1) ? over_r : over_r + 32'd1;
  assign kept_inc = (kept_r == '1) ? kept_r : kept_r + 1'b1;
  // ceil(seen * tol / 256) as (product + 255) >> 8
  assign thr_sum  = 41'(prod_r) + 41'd255;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ordered_r <= 1'b0;
      larger_r  <= 1'b0;
      near_en_r <= 1'b0;
      near_r    <= '0;
      far_r     <= '0;
      limit_r   <= -10'sd1;
      tol_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rsf_pkg::REG_ORDERED:   ordered_r <= cfg_wdata[0];
        rsf_pkg::REG_LARGER:    larger_r  <= cfg_wdata[0];
        rsf_pkg::REG_NEAR_EN:   near_en_r <= cfg_wdata[0];
        rsf_pkg::REG_NEAR:      near_r    <= cfg_wdata;
        rsf_pkg::REG_FAR:       far_r     <= cfg_wdata;
        rsf_pkg::REG_LIMIT:     limit_r   <= cfg_wdata[9:0];
        rsf_pkg::REG_TOLERANCE: tol_r     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // next state; decide waits until the output register can take the result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rsf_pkg::T_IDLE: if (accept) state_nxt = rsf_pkg::T_MUL;
      rsf_pkg::T_MUL:  state_nxt = rsf_pkg::T_EVAL;
      rsf_pkg::T_EVAL: begin
        if (res_ready) begin
          if (heap_req.start) state_nxt = rsf_pkg::T_HEAP;
          else state_nxt = rsf_pkg::T_IDLE;
        end
      end
      rsf_pkg::T_HEAP: if (heap_rsp.done && res_ready) state_nxt = rsf_pkg::T_IDLE;
      default: state_nxt = rsf_pkg::T_IDLE;
    endcase
  end

  // decision datapath
  always_comb begin
    heap_cnt_nxt   = heap_cnt_r;
    tight_nxt      = tight_r;
    seen_nxt       = seen_r;
    over_nxt       = over_r;
    kept_nxt       = kept_r;
    stopped_nxt    = stopped_r;
    prod_nxt       = prod_r;
    keep_nxt       = keep_r;
    stop_nxt       = stop_r;
    op_nxt         = op_r;
    heap_req.start = 1'b0;
    heap_req.op    = op_r;
    heap_req.count = heap_cnt_r;
    heap_req.dval  = dist_r;
    done_eval      = 1'b0;
    case (state_r)
      rsf_pkg::T_IDLE: begin
        // first candidate of a query restarts the per-query state
        if (accept && in_first_of_query) begin
          heap_cnt_nxt = '0;
          tight_nxt    = far_r;
          seen_nxt     = '0;
          over_nxt     = '0;
          kept_nxt     = '0;
          stopped_nxt  = 1'b0;
        end
      end
      rsf_pkg::T_MUL: begin
        if (!stopped_r && !lim_zero && !ordered_r) begin
          seen_nxt = seen_inc;
        end
        prod_nxt = 40'(seen_inc) * 40'(tol_r);
      end
      rsf_pkg::T_EVAL: begin
        // state changes once, on the cycle the result can move on
        if (res_ready) begin
          done_eval = 1'b1;
          keep_nxt  = 1'b0;
          stop_nxt  = 1'b0;
          if (stopped_r || lim_zero) begin
            stop_nxt = 1'b1;
          end else if (ordered_r) begin
            if (near_en_r && rsf_pkg::closer(dist_r, near_r, larger_r)) begin
              stop_nxt = 1'b0;
            end else if (!rsf_pkg::closer(dist_r, far_r, larger_r)) begin
              stop_nxt = 1'b1;
            end else begin
              keep_nxt = 1'b1;
              kept_nxt = kept_inc;
              if (has_lim && kept_inc >= lim_eff) stop_nxt = 1'b1;
            end
          end else begin
            if (near_en_r && rsf_pkg::closer(dist_r, near_r, larger_r)) begin
              stop_nxt = 1'b0;
            end else if (!rsf_pkg::closer(dist_r, tight_r, larger_r)) begin
              over_nxt = over_inc;
              if ({1'b0, over_inc} > thr_sum[40:8]) stop_nxt = 1'b1;
            end else begin
              if (has_lim) begin
                heap_req.start = 1'b1;
                if (heap_cnt_r < lim_eff) begin
                  heap_req.op  = rsf_pkg::HOP_INSERT;
                  heap_cnt_nxt = heap_cnt_r + 1'b1;
                end else begin
                  heap_req.op = rsf_pkg::HOP_REPLACE;
                end
                op_nxt = heap_req.op;
              end
              over_nxt = '0;
              kept_nxt = kept_inc;
              keep_nxt = 1'b1;
            end
          end
          if (stop_nxt) stopped_nxt = 1'b1;
        end
      end
      rsf_pkg::T_HEAP: begin
        // tighten the unordered bound to the worst of the refreshed set
        if (heap_rsp.done && op_r == rsf_pkg::HOP_REPLACE) tight_nxt = heap_rsp.worst;
      end
      default: ;
    endcase
  end

  // result register: loaded on the cycle the sequencer leaves for idle
  assign out_load = ((state_r == rsf_pkg::T_EVAL && !heap_req.start) ||
                     (state_r == rsf_pkg::T_HEAP && heap_rsp.done)) && res_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsf_pkg::T_IDLE;
      out_valid_r <= 1'b0;
      heap_cnt_r  <= '0;
      tight_r     <= '0;
      seen_r      <= '0;
      over_r      <= '0;
      kept_r      <= '0;
      stopped_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      heap_cnt_r  <= heap_cnt_nxt;
      tight_r     <= tight_nxt;
      seen_r      <= seen_nxt;
      over_r      <= over_nxt;
      kept_r      <= kept_nxt;
      stopped_r   <= stopped_nxt;
    end
    prod_r <= prod_nxt;
    op_r   <= op_nxt;
    if (done_eval) begin
      keep_r <= keep_nxt;
      stop_r <= stop_nxt;
    end
    if (accept) begin
      id_r   <= in_cand_id;
      dist_r <= in_cand_dist;
    end
    if (out_load) begin
      out_keep_r <= (state_r == rsf_pkg::T_EVAL) ? keep_nxt : keep_r;
      out_stop_r <= (state_r == rsf_pkg::T_EVAL) ? stop_nxt : stop_r;
      out_id_r   <= id_r;
      out_dist_r <= dist_r;
    end
  end

  rsf_heap u_heap (
    .clk           (clk),
    .rst_n         (rst_n),
    .prefer_larger (larger_r),
    .req           (heap_req),
    .rsp           (heap_rsp)
  );

  assign out_valid = out_valid_r;
  assign out_keep  = out_keep_r;
  assign out_stop  = out_stop_r;
  assign out_id    = out_id_r;
  assign out_dist  = out_dist_r;

endmodule

[sv/rsf_checker.sv]
// Port-level checker for range_search_stream_filter, with its bind.
// Depends on range_search_stream_filter_defines.svh.
`timescale 1ns / 1ps
`include "range_search_stream_filter_defines.svh"

module rsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_keep,
  input logic        out_stop,
  input logic [62:0] out_id
);

  // a transfer in is followed by in_stall through the multiply and decide steps
  `RSF_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)
  `RSF_ASSERT_NEXT(a_busy_two, in_valid && !in_stall, ##1 in_stall)
  // result held while stalled
  `RSF_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_id) && $stable(out_keep) && $stable(out_stop))

endmodule

bind range_search_stream_filter rsf_checker u_rsf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_keep  (out_keep),
  .out_stop  (out_stop),
  .out_id    (out_id)
);
